FILE: rtl/core/oaht_pkg.sv
package oaht_pkg;

    localparam int SLOTS_DEF   = 256;

    localparam int OP_W        = 2;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_IDX_W  = 8;
    localparam int COUNT_OUT_W = 9;

    // wide enough for 5*slot+1 at the largest table size
    localparam int OAHT_VW     = 20;

    localparam int PROBE_STRIDE = 5;
    localparam int PROBE_OFFSET = 1;

    typedef enum logic [OP_W-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK   = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_LIVE    = 2'd1,
        ST_DELETED = 2'd2
    } t_slot_st;

    typedef struct packed {
        t_slot_st             st;
        logic [KEY_W-1:0]     key;
    } t_sk_entry;

    // brings x below m where x is known to stay under 5*m
    function automatic logic [OAHT_VW-1:0] mod_sub(input logic [OAHT_VW-1:0] x,
                                                   input logic [OAHT_VW-1:0] m);
        logic [OAHT_VW-1:0] t;
        t = x;
        for (int k = 0; k < 4; k++) begin
            if (t >= m) begin
                t = t - m;
            end
        end
        return t;
    endfunction

endpackage

FILE: rtl/core/oaht_intf.sv
interface oaht_req_if;
    logic                        valid;
    logic                        ready;
    logic [oaht_pkg::OP_W-1:0]   op;
    logic [oaht_pkg::KEY_W-1:0]  key;
    logic [oaht_pkg::VAL_W-1:0]  value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface oaht_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [oaht_pkg::STATUS_W-1:0]     status;
    logic [oaht_pkg::SLOT_IDX_W-1:0]   slot_index;
    logic [oaht_pkg::VAL_W-1:0]        read_value;
    logic [oaht_pkg::COUNT_OUT_W-1:0]  entry_count_out;

    modport source (output valid, output status, output slot_index, output read_value,
                    output entry_count_out, input ready);
    modport sink   (input valid, input status, input slot_index, input read_value,
                    input entry_count_out, output ready);
endinterface

FILE: rtl/core/open_addressing_hash_table.sv
// Open-addressing key/value table of SLOTS entries (search, insert or overwrite,
// delete, get with default). One transaction is handled at a time; each request
// yields exactly one response. After reset the slot memory is swept clear, one
// slot a cycle, before the first request is taken. For a request the block then
// hashes the key, probes P slots (1 to SLOTS) in turn, since the single read port
// of the slot memory looks at one slot a cycle, and loads the response register;
// with a SLOTS that is not a power of two the key reduction is done serially. A
// new request is taken while an earlier response still waits in the output
// register.
module open_addressing_hash_table #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oaht_req_if.sink    i_req,
    oaht_rsp_if.source  o_rsp
);
    import oaht_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [OAHT_VW-1:0] SLOTS_V = OAHT_VW'(SLOTS);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_CHECK  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;

    t_sk_entry          mem_sk [SLOTS];
    logic [VAL_W-1:0]   mem_v  [SLOTS];

    logic [IW-1:0]      r_clr;
    logic [IW-1:0]      r_probe;
    logic [IW-1:0]      r_i;
    logic               r_free_vld;
    logic [IW-1:0]      r_free_slot;
    logic               r_hit;
    logic [IW-1:0]      r_hit_slot;
    logic [CW-1:0]      r_count;
    t_op                r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;
    t_sk_entry          r_sk_q;
    logic [VAL_W-1:0]   r_v_q;

    logic               r_out_vld;
    t_status            r_out_status;
    logic [SLOT_IDX_W-1:0]  r_out_slot;
    logic [VAL_W-1:0]       r_out_rd;
    logic [COUNT_OUT_W-1:0] r_out_cnt;

    logic               accept;
    logic               h_done;
    logic [IW-1:0]      h_slot;
    logic [IW-1:0]      n_probe;
    logic               hit_now;
    logic               stop_now;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               out_free;
    logic               load_out;

    logic               wr_sk_en;
    logic [IW-1:0]      wr_sk_addr;
    t_sk_entry          wr_sk_data;
    logic               wr_v_en;
    logic [IW-1:0]      wr_v_addr;
    logic [CW-1:0]      cnt_new;
    t_status            res_status;
    logic [IW-1:0]      res_slot;
    logic [VAL_W-1:0]   res_rd;

    assign accept   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free = !r_out_vld || o_rsp.ready;
    assign load_out = (r_state == S_FINISH) && out_free;

    oaht_hash #(.SLOTS(SLOTS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_req.key),
        .o_done  (h_done),
        .o_slot  (h_slot)
    );

    assign n_probe  = IW'(mod_sub(OAHT_VW'(r_probe) + OAHT_VW'(PROBE_STRIDE), SLOTS_V));
    assign hit_now  = (r_sk_q.st == ST_LIVE) && (r_sk_q.key == r_key);
    assign stop_now = hit_now || (r_sk_q.st == ST_EMPTY) || (r_i == IW'(SLOTS - 1));

    // read only when a probe is issued, so the last probed entry stays in the registers
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_probe;
        if (r_state == S_HASH && h_done) begin
            rd_en   = 1'b1;
            rd_addr = h_slot;
        end else if (r_state == S_CHECK && !stop_now) begin
            rd_en   = 1'b1;
            rd_addr = n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_sk_q <= mem_sk[rd_addr];
            r_v_q  <= mem_v[rd_addr];
        end
        if (wr_sk_en) begin
            mem_sk[wr_sk_addr] <= wr_sk_data;
        end
        if (wr_v_en) begin
            mem_v[wr_v_addr] <= r_val;
        end
    end

    always_comb begin
        wr_sk_en   = 1'b0;
        wr_sk_addr = r_hit_slot;
        wr_sk_data = '{st: ST_LIVE, key: r_key};
        wr_v_en    = 1'b0;
        wr_v_addr  = r_hit_slot;
        cnt_new    = r_count;
        res_status = RES_MISS;
        res_slot   = '0;
        res_rd     = '0;
        if (r_state == S_CLEAR) begin
            wr_sk_en   = 1'b1;
            wr_sk_addr = r_clr;
            wr_sk_data = '{st: ST_EMPTY, key: '0};
        end else if (load_out) begin
            unique case (r_op)
                OP_SEARCH: begin
                    if (r_hit) begin
                        res_status = RES_OK;
                        res_slot   = r_hit_slot;
                    end
                end
                OP_INSERT: begin
                    if (r_hit) begin
                        wr_v_en    = 1'b1;
                        res_status = RES_OK;
                        res_slot   = r_hit_slot;
                    end else if (r_free_vld) begin
                        wr_sk_en   = 1'b1;
                        wr_sk_addr = r_free_slot;
                        wr_v_en    = 1'b1;
                        wr_v_addr  = r_free_slot;
                        cnt_new    = r_count + CW'(1);
                        res_status = RES_OK;
                        res_slot   = r_free_slot;
                    end else begin
                        res_status = RES_FULL;
                    end
                end
                OP_DELETE: begin
                    if (r_hit) begin
                        wr_sk_en   = 1'b1;
                        wr_sk_data = '{st: ST_DELETED, key: r_key};
                        if (r_count != '0) begin
                            cnt_new = r_count - CW'(1);
                        end
                        res_status = RES_OK;
                        res_slot   = r_hit_slot;
                    end
                end
                OP_GET: begin
                    if (r_hit) begin
                        res_status = RES_OK;
                        res_slot   = r_hit_slot;
                        res_rd     = r_v_q;
                    end else begin
                        res_rd     = r_val;
                    end
                end
                default: begin
                    res_status = RES_MISS;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == IW'(SLOTS - 1)) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_HASH;
            S_HASH:   if (h_done) n_state = S_CHECK;
            S_CHECK:  if (stop_now) n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (load_out) begin
                r_count   <= cnt_new;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_op'(i_req.op);
            r_key <= i_req.key;
            r_val <= i_req.value;
        end
        if (r_state == S_HASH && h_done) begin
            r_probe    <= h_slot;
            r_i        <= '0;
            r_free_vld <= 1'b0;
        end else if (r_state == S_CHECK) begin
            // first empty or deleted slot on the path is where an insert lands
            if (!r_free_vld && r_sk_q.st != ST_LIVE) begin
                r_free_vld  <= 1'b1;
                r_free_slot <= r_probe;
            end
            if (stop_now) begin
                r_hit      <= hit_now;
                r_hit_slot <= r_probe;
            end else begin
                r_probe <= n_probe;
                r_i     <= r_i + IW'(1);
            end
        end
        if (load_out) begin
            r_out_status <= res_status;
            r_out_slot   <= SLOT_IDX_W'(res_slot);
            r_out_rd     <= res_rd;
            r_out_cnt    <= COUNT_OUT_W'(cnt_new);
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.slot_index      = r_out_slot;
    assign o_rsp.read_value      = r_out_rd;
    assign o_rsp.entry_count_out = r_out_cnt;

endmodule

FILE: rtl/core/oaht_hash.sv
module oaht_hash #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [oaht_pkg::KEY_W-1:0]    i_key,
    output logic                          o_done,
    output logic [$clog2(SLOTS)-1:0]      o_slot
);
    import oaht_pkg::*;

    localparam int  IW      = $clog2(SLOTS);
    localparam bit  IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int  BPS     = 4;
    localparam int  STEPS   = KEY_W / BPS;
    localparam int  CNT_W   = $clog2(STEPS);
    localparam logic [IW:0]         SLOTS_E = (IW+1)'(SLOTS);
    localparam logic [OAHT_VW-1:0]  SLOTS_V = OAHT_VW'(SLOTS);

    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [KEY_W-1:0]   r_key;
    logic [IW-1:0]      r_rem;
    logic [IW-1:0]      r_slot;

    logic [IW-1:0]      n_rem;
    logic [IW:0]        step_t;
    logic [OAHT_VW-1:0] lin;
    logic [OAHT_VW-1:0] red;

    // key mod SLOTS, most significant bits first, four bits a cycle
    always_comb begin
        n_rem = r_rem;
        step_t = '0;
        for (int b = 0; b < BPS; b++) begin
            step_t = {n_rem, r_key[KEY_W-1-b]};
            if (step_t >= SLOTS_E) begin
                step_t = step_t - SLOTS_E;
            end
            n_rem = step_t[IW-1:0];
        end
    end

    assign lin = (OAHT_VW'(r_rem) << 2) + OAHT_VW'(r_rem) + OAHT_VW'(PROBE_OFFSET);
    assign red = mod_sub(lin, SLOTS_V);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (IS_POW2) begin
                    r_fin <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_rem <= IS_POW2 ? i_key[IW-1:0] : '0;
        end else if (r_busy) begin
            r_key <= r_key << BPS;
            r_rem <= n_rem;
        end
        if (r_fin) begin
            r_slot <= red[IW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_slot = r_slot;

endmodule

FILE: tb/tb_open_addressing_hash_table.sv
module tb_open_addressing_hash_table;
    import oaht_pkg::*;

    localparam int N_SLOTS = SLOTS_DEF;

    // idling modes, one per stretch of the run
    localparam int PH_FREE   = 0;
    localparam int PH_SRC    = 1;
    localparam int PH_SNK    = 2;
    localparam int PH_BOTH   = 3;

    localparam int MAX_SHOWN = 10;
    localparam int TAIL_CYC  = 3 * N_SLOTS;

    typedef struct {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        int                phase;
    } t_req_item;

    typedef struct {
        t_status                 status;
        logic [SLOT_IDX_W-1:0]   slot;
        logic [VAL_W-1:0]        rdval;
        logic [COUNT_OUT_W-1:0]  count;
    } t_rsp_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    oaht_req_if req_if();
    oaht_rsp_if rsp_if();

    open_addressing_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the table
    t_slot_st               tbl_st  [N_SLOTS];
    logic [KEY_W-1:0]       tbl_key [N_SLOTS];
    logic [VAL_W-1:0]       tbl_val [N_SLOTS];
    logic [COUNT_OUT_W-1:0] live_n;

    t_req_item req_backlog[$];
    t_rsp_item rsp_due[$];
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] fill_keys[$];

    int cur_phase;
    int mismatch_n;

    function automatic int probe_at(logic [KEY_W-1:0] key, int i);
        int b;
        b = int'(key[7:0]);
        return (PROBE_STRIDE * (b + i) + PROBE_OFFSET) % N_SLOTS;
    endfunction

    function automatic t_rsp_item table_apply(t_req_item r);
        t_rsp_item o;
        int hit_at;
        int j;
        o.status = RES_MISS;
        o.slot   = '0;
        o.rdval  = '0;
        hit_at   = -1;
        for (int i = 0; i < N_SLOTS; i++) begin
            j = probe_at(r.key, i);
            if (tbl_st[j] == ST_LIVE && tbl_key[j] == r.key) begin
                hit_at = j;
                break;
            end
            if (tbl_st[j] == ST_EMPTY) break;
        end
        case (r.op)
            OP_SEARCH: begin
                if (hit_at >= 0) begin
                    o.status = RES_OK;
                    o.slot   = hit_at[SLOT_IDX_W-1:0];
                end
            end
            OP_INSERT: begin
                if (hit_at >= 0) begin
                    tbl_val[hit_at] = r.value;
                    o.status = RES_OK;
                    o.slot   = hit_at[SLOT_IDX_W-1:0];
                end else begin
                    o.status = RES_FULL;
                    for (int i = 0; i < N_SLOTS; i++) begin
                        j = probe_at(r.key, i);
                        if (tbl_st[j] != ST_LIVE) begin
                            tbl_st[j]  = ST_LIVE;
                            tbl_key[j] = r.key;
                            tbl_val[j] = r.value;
                            live_n     = live_n + 1'b1;
                            o.status   = RES_OK;
                            o.slot     = j[SLOT_IDX_W-1:0];
                            break;
                        end
                    end
                end
            end
            OP_DELETE: begin
                if (hit_at >= 0) begin
                    tbl_st[hit_at] = ST_DELETED;
                    if (live_n != '0) live_n = live_n - 1'b1;
                    o.status = RES_OK;
                    o.slot   = hit_at[SLOT_IDX_W-1:0];
                end
            end
            default: begin
                if (hit_at >= 0) begin
                    o.status = RES_OK;
                    o.slot   = hit_at[SLOT_IDX_W-1:0];
                    o.rdval  = tbl_val[hit_at];
                end else begin
                    o.rdval  = r.value;
                end
            end
        endcase
        o.count = live_n;
        return o;
    endfunction

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int src_idle_pct(int ph);
        return (ph == PH_SRC) ? 61 : (ph == PH_BOTH) ? 38 : 0;
    endfunction

    function automatic int snk_stall_pct(int ph);
        return (ph == PH_SNK) ? 61 : (ph == PH_BOTH) ? 38 : 0;
    endfunction

    task automatic add_item(t_op op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                            int phase);
        t_req_item r;
        r.op    = op;
        r.key   = key;
        r.value = value;
        r.phase = phase;
        req_backlog.push_back(r);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom();
    endfunction

    // mostly keys already in play, some colliding on the low byte, some fresh
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (key_pool.size() == 0 || r < 25) begin
            k = $urandom();
            key_pool.push_back(k);
        end else if (r < 75) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            k[KEY_W-1:8] = (KEY_W-8)'($urandom());
            key_pool.push_back(k);
        end
        if (key_pool.size() > 48) void'(key_pool.pop_front());
        return k;
    endfunction

    task automatic add_random(int n, int phase);
        int r;
        t_op op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35)      op = OP_INSERT;
            else if (r < 55) op = OP_SEARCH;
            else if (r < 75) op = OP_DELETE;
            else             op = OP_GET;
            add_item(op, pick_key(), pick_value(), phase);
        end
    endtask

    task automatic build_stimulus();
        int idx;
        logic [KEY_W-1:0] k;
        // empty table, absent keys
        add_item(OP_SEARCH, 32'h0000_0000, 32'h0000_0000, PH_FREE);
        add_item(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, PH_FREE);
        add_item(OP_DELETE, 32'h1234_5678, 32'h0000_0000, PH_FREE);
        // extremes, then a chain of keys sharing one home slot
        add_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000, PH_FREE);
        add_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PH_FREE);
        add_item(OP_INSERT, 32'h0000_0100, 32'hA5A5_A5A5, PH_FREE);
        add_item(OP_INSERT, 32'h0000_0200, 32'h5A5A_5A5A, PH_FREE);
        add_item(OP_SEARCH, 32'h0000_0200, 32'h0000_0000, PH_FREE);
        add_item(OP_GET,    32'h0000_0100, 32'h0000_0000, PH_FREE);
        // overwrite in place
        add_item(OP_INSERT, 32'h0000_0100, 32'h8000_0001, PH_FREE);
        add_item(OP_GET,    32'h0000_0100, 32'hFFFF_FFFF, PH_FREE);
        // delete in the middle of the chain, later probes must skip it
        add_item(OP_DELETE, 32'h0000_0100, 32'h0000_0000, PH_FREE);
        add_item(OP_SEARCH, 32'h0000_0200, 32'h0000_0000, PH_FREE);
        add_item(OP_GET,    32'h0000_0100, 32'h1234_5678, PH_FREE);
        add_item(OP_DELETE, 32'h0000_0100, 32'h0000_0000, PH_FREE);
        // reuse of the deleted slot
        add_item(OP_INSERT, 32'h0000_0300, 32'h0F0F_0F0F, PH_FREE);
        add_item(OP_SEARCH, 32'h0000_0000, 32'h0000_0000, PH_FREE);
        add_item(OP_GET,    32'hFFFF_FFFF, 32'h0000_0000, PH_FREE);
        add_item(OP_DELETE, 32'h0000_0000, 32'h0000_0000, PH_FREE);
        add_item(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, PH_FREE);
        add_item(OP_DELETE, 32'h0000_0200, 32'h0000_0000, PH_FREE);
        add_item(OP_DELETE, 32'h0000_0300, 32'h0000_0000, PH_FREE);
        add_item(OP_SEARCH, 32'h0000_0300, 32'h0000_0000, PH_FREE);

        add_random(40, PH_FREE);
        add_random(40, PH_SRC);

        // fill to the brim, then inserts of new keys must report full
        for (int i = 0; i < N_SLOTS + 6; i++) begin
            k = $urandom();
            fill_keys.push_back(k);
            add_item(OP_INSERT, k, pick_value(), PH_SNK);
        end
        for (int i = 0; i < 30; i++) begin
            k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
            case ($urandom_range(0, 4))
                0: add_item(OP_SEARCH, k, pick_value(), PH_SNK);
                1: add_item(OP_GET, k, pick_value(), PH_SNK);
                2: add_item(OP_INSERT, k, pick_value(), PH_SNK);
                3: add_item(OP_INSERT, $urandom(), pick_value(), PH_SNK);
                default: add_item(OP_SEARCH, $urandom(), pick_value(), PH_SNK);
            endcase
        end

        // thin the table out again
        for (int i = 0; i < 150; i++) begin
            idx = $urandom_range(0, fill_keys.size() - 1);
            add_item(OP_DELETE, fill_keys[idx], pick_value(), PH_BOTH);
            fill_keys.delete(idx);
        end
        add_random(30, PH_BOTH);
        add_random(30, PH_FREE);
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_p
        t_req_item r;
        t_req_item acc;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                acc.op    = t_op'(req_if.op);
                acc.key   = req_if.key;
                acc.value = req_if.value;
                acc.phase = cur_phase;
                rsp_due.push_back(table_apply(acc));
                void'(req_backlog.pop_front());
            end
            if (!(req_if.valid && !req_if.ready)) begin
                if (req_backlog.size() != 0 && !coin(src_idle_pct(req_backlog[0].phase))) begin
                    r = req_backlog[0];
                    req_if.op    <= r.op;
                    req_if.key   <= r.key;
                    req_if.value <= r.value;
                    req_if.valid <= 1'b1;
                    cur_phase    <= r.phase;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin : watch_p
        t_rsp_item want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_due.size() == 0) begin
                    mismatch_n = mismatch_n + 1;
                    if (mismatch_n <= MAX_SHOWN)
                        $display("unexpected transaction: status %0d slot %0d value %h count %0d",
                                 rsp_if.status, rsp_if.slot_index, rsp_if.read_value,
                                 rsp_if.entry_count_out);
                end else begin
                    want = rsp_due.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.slot_index !== want.slot ||
                        rsp_if.read_value !== want.rdval ||
                        rsp_if.entry_count_out !== want.count) begin
                        mismatch_n = mismatch_n + 1;
                        if (mismatch_n <= MAX_SHOWN)
                            $display("mismatch: st %0d/%0d slot %0d/%0d val %h/%h cnt %0d/%0d",
                                     want.status, rsp_if.status, want.slot, rsp_if.slot_index,
                                     want.rdval, rsp_if.read_value, want.count,
                                     rsp_if.entry_count_out);
                    end
                end
            end
            rsp_if.ready <= !coin(snk_stall_pct(cur_phase));
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.op    = OP_SEARCH;
        req_if.key   = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        cur_phase    = PH_FREE;
        mismatch_n   = 0;
        live_n       = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            tbl_st[i]  = ST_EMPTY;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        build_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (req_backlog.size() != 0 || req_if.valid) @(posedge i_clk);
        while (rsp_due.size() != 0) @(posedge i_clk);
        // room for any stray transaction to show up
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatch_n == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/oaht_pkg.sv
rtl/core/oaht_intf.sv
rtl/core/oaht_hash.sv
rtl/core/open_addressing_hash_table.sv
tb/tb_open_addressing_hash_table.sv
